// File: rtl/core/psg_register_frame_player_assert.svh
// ----------------------------------------------------------------------------
// psg_register_frame_player_assert.svh
// Assertion macros used by the frame player checker.
// ----------------------------------------------------------------------------
`ifndef PSG_REGISTER_FRAME_PLAYER_ASSERT_SVH
`define PSG_REGISTER_FRAME_PLAYER_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define PSGFP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent.
`define PSGFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/psgfp_pkg.sv
// ----------------------------------------------------------------------------
// psgfp_pkg
// Shared constants, codes and handshake types of the register frame player.
// ----------------------------------------------------------------------------
`default_nettype none

package psgfp_pkg;

    localparam int SECTORS_DEF      = 8;
    localparam int SECTOR_BYTES_DEF = 512;

    localparam int IDX_W       = 12;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 32;
    localparam int RADDR_W     = 4;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_W       = 32;
    localparam int FRAME_BYTES = 16;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_START = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 1'b1;

    // Frame byte that suppresses the register 13 write
    localparam logic [BYTE_W-1:0] SKIP_MARK = 8'd255;

    // Sound chip register numbers with a role in sequencing
    localparam logic [RADDR_W-1:0] B12_ADDR       = 4'd12;
    localparam logic [RADDR_W-1:0] B13_ADDR       = 4'd13;
    localparam logic [RADDR_W-1:0] LAST_MUTE_ADDR = 4'd15;

    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] value;
    } red_req_t;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] value;
    } red_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/psgfp_ram.sv
// ----------------------------------------------------------------------------
// psgfp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module psgfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/psgfp_reduce.sv
// ----------------------------------------------------------------------------
// psgfp_reduce
// Reduces a 12-bit ring position modulo the ring size, one
// compare-and-subtract step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psgfp_reduce #(
    parameter int RING = psgfp_pkg::SECTORS_DEF * psgfp_pkg::SECTOR_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  psgfp_pkg::red_req_t req,
    output psgfp_pkg::red_rsp_t rsp
);

    import psgfp_pkg::*;

    localparam int AW    = $clog2(RING);
    localparam int CW    = ((AW + 1) > IDX_W) ? (AW + 1) : IDX_W;
    localparam int SPAN  = 1 << IDX_W;
    localparam int K_TOP = (RING >= SPAN) ? 0 : $clog2((SPAN + RING - 1) / RING) - 1;
    localparam int KW    = (K_TOP > 0) ? $clog2(K_TOP + 1) : 1;

    logic             busy_reg;
    logic             busy_next;
    logic [KW-1:0]    k_reg;
    logic [KW-1:0]    k_next;
    logic [IDX_W-1:0] x_reg;
    logic [IDX_W-1:0] x_next;
    logic [IDX_W-1:0] x_step;
    logic [IDX_W-1:0] x_shr;
    logic [IDX_W-1:0] sub;
    logic             fits;

    // Subtract RING * 2^k while it fits
    always_comb
    begin
        x_shr  = x_reg >> k_reg;
        fits   = CW'(x_shr) >= CW'(RING);
        sub    = IDX_W'(CW'(RING) << k_reg);
        x_step = fits ? (x_reg - sub) : x_reg;
    end

    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        x_next    = x_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            k_next    = KW'(K_TOP);
            x_next    = req.value;
        end
        else if (busy_reg)
        begin
            x_next = x_step;
            if (k_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                k_next = k_reg - KW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
    end

    assign rsp.done  = busy_reg && (k_reg == '0);
    assign rsp.value = x_step;

endmodule

`default_nettype wire

// File: rtl/core/psgfp_player.sv
// ----------------------------------------------------------------------------
// psgfp_player
// Item sequencer: ring loads, playback start, and per-tick register write
// streaming from the ring RAM (or mute writes when no frames are left) through a one-entry output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psgfp_player #(
    parameter int SECTORS      = psgfp_pkg::SECTORS_DEF,
    parameter int SECTOR_BYTES = psgfp_pkg::SECTOR_BYTES_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      item_valid,
    output logic                                      item_stall,
    input  logic [psgfp_pkg::MODE_W-1:0]              mode,
    input  logic [psgfp_pkg::IDX_W-1:0]               load_index,
    input  logic [psgfp_pkg::BYTE_W-1:0]              load_byte,
    input  logic [psgfp_pkg::COUNT_W-1:0]             cfg_frame_count,
    input  logic [psgfp_pkg::IDX_W-1:0]               cfg_start_offset,
    output psgfp_pkg::red_req_t                       red_req,
    input  psgfp_pkg::red_rsp_t                       red_rsp,
    output logic                                      ram_we,
    output logic [$clog2(SECTORS*SECTOR_BYTES)-1:0]   ram_waddr,
    output logic [psgfp_pkg::BYTE_W-1:0]              ram_wdata,
    output logic                                      ram_re,
    output logic [$clog2(SECTORS*SECTOR_BYTES)-1:0]   ram_raddr,
    input  logic [psgfp_pkg::BYTE_W-1:0]              ram_rdata,
    output logic                                      result_valid,
    input  logic                                      result_stall,
    output logic [psgfp_pkg::RADDR_W-1:0]             reg_addr,
    output logic [psgfp_pkg::BYTE_W-1:0]              reg_data,
    output logic                                      last
);

    import psgfp_pkg::*;

    localparam int RING = SECTORS * SECTOR_BYTES;
    localparam int AW   = $clog2(RING);
    localparam int PW   = AW + 1;
    localparam int XW   = (AW > IDX_W) ? AW : IDX_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_REDUCE = 4'b0010,
        S_PLAY   = 4'b0100,
        S_MUTE   = 4'b1000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [COUNT_W-1:0]   frames_left_reg;
    logic [COUNT_W-1:0]   frames_left_next;
    logic [AW-1:0]        ptr_reg;
    logic [AW-1:0]        ptr_next;
    logic                 is_load_reg;
    logic                 is_load_next;
    logic [RADDR_W-1:0]   rd_cnt_reg;
    logic [RADDR_W-1:0]   rd_cnt_next;
    logic                 rd_more_reg;
    logic                 rd_more_next;
    logic                 pend_reg;
    logic                 pend_next;
    logic                 emit13_reg;
    logic                 emit13_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [BYTE_W-1:0]    load_byte_reg;
    logic [BYTE_W-1:0]    load_byte_next;
    logic [RADDR_W-1:0]   pend_idx_reg;
    logic [RADDR_W-1:0]   pend_idx_next;
    logic [BYTE_W-1:0]    b13_reg;
    logic [BYTE_W-1:0]    b13_next;
    logic [RADDR_W-1:0]   out_addr_reg;
    logic [RADDR_W-1:0]   out_addr_next;
    logic [BYTE_W-1:0]    out_data_reg;
    logic [BYTE_W-1:0]    out_data_next;
    logic                 out_last_reg;
    logic                 out_last_next;

    logic                 accept;
    logic                 out_free;
    logic                 has13;
    logic                 move;
    logic                 issue;
    logic                 emit_data;
    logic                 emit13;
    logic                 mute_emit;
    logic                 finish_play;
    logic [PW-1:0]        rd_sum;
    logic [AW-1:0]        rd_addr;
    logic [PW-1:0]        adv_sum;
    logic [AW-1:0]        ptr_adv;
    logic [XW-1:0]        red_wide;
    logic [AW-1:0]        red_ptr;

    // Ring address arithmetic, wrapped at the ring size
    always_comb
    begin
        rd_sum   = {1'b0, ptr_reg} + PW'(rd_cnt_reg);
        rd_addr  = (rd_sum >= PW'(RING)) ? AW'(rd_sum - PW'(RING)) : AW'(rd_sum);
        adv_sum  = {1'b0, ptr_reg} + PW'(FRAME_BYTES);
        ptr_adv  = (adv_sum >= PW'(RING)) ? AW'(adv_sum - PW'(RING)) : AW'(adv_sum);
        red_wide = XW'(red_rsp.value);
        red_ptr  = red_wide[AW-1:0];
    end

    // Read-ahead control: RAM data register holds one byte until consumed
    always_comb
    begin
        accept      = item_valid && (state_reg == S_IDLE);
        out_free    = !out_valid_reg || !result_stall;
        has13       = (b13_reg != SKIP_MARK);
        move        = (state_reg == S_PLAY) && pend_reg
                      && ((pend_idx_reg == B13_ADDR) || out_free);
        issue       = (state_reg == S_PLAY) && rd_more_reg && (!pend_reg || move);
        emit_data   = move && (pend_idx_reg != B13_ADDR);
        emit13      = (state_reg == S_PLAY) && emit13_reg && out_free;
        mute_emit   = (state_reg == S_MUTE) && out_free;
        finish_play = (emit_data && (pend_idx_reg == B12_ADDR) && !has13) || emit13;
    end

    always_comb
    begin
        state_next       = state_reg;
        frames_left_next = frames_left_reg;
        ptr_next         = ptr_reg;
        is_load_next     = is_load_reg;
        rd_cnt_next      = rd_cnt_reg;
        rd_more_next     = rd_more_reg;
        pend_next        = pend_reg;
        emit13_next      = emit13_reg;
        load_byte_next   = load_byte_reg;
        pend_idx_next    = pend_idx_reg;
        b13_next         = b13_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        MODE_LOAD:
                        begin
                            is_load_next   = 1'b1;
                            load_byte_next = load_byte;
                            state_next     = S_REDUCE;
                        end
                        MODE_START:
                        begin
                            is_load_next     = 1'b0;
                            frames_left_next = cfg_frame_count;
                            state_next       = S_REDUCE;
                        end
                        MODE_TICK:
                        begin
                            if (frames_left_reg != '0)
                            begin
                                state_next   = S_PLAY;
                                rd_cnt_next  = B13_ADDR;
                                rd_more_next = 1'b1;
                                pend_next    = 1'b0;
                                emit13_next  = 1'b0;
                            end
                            else
                            begin
                                state_next  = S_MUTE;
                                rd_cnt_next = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_REDUCE:
            begin
                if (red_rsp.done)
                begin
                    if (!is_load_reg)
                    begin
                        ptr_next = red_ptr;
                    end
                    state_next = S_IDLE;
                end
            end
            S_PLAY:
            begin
                // register 13 byte is fetched first so last can be set on 12
                if (issue)
                begin
                    pend_idx_next = rd_cnt_reg;
                    rd_cnt_next   = (rd_cnt_reg == B13_ADDR) ? '0
                                                             : rd_cnt_reg + RADDR_W'(1);
                    rd_more_next  = (rd_cnt_reg != B12_ADDR);
                end
                pend_next = issue ? 1'b1 : (move ? 1'b0 : pend_reg);
                if (move && (pend_idx_reg == B13_ADDR))
                begin
                    b13_next = ram_rdata;
                end
                if (emit_data && (pend_idx_reg == B12_ADDR) && has13)
                begin
                    emit13_next = 1'b1;
                end
                if (finish_play)
                begin
                    emit13_next      = 1'b0;
                    frames_left_next = frames_left_reg - COUNT_W'(1);
                    ptr_next         = ptr_adv;
                    state_next       = S_IDLE;
                end
            end
            S_MUTE:
            begin
                if (mute_emit)
                begin
                    rd_cnt_next = rd_cnt_reg + RADDR_W'(1);
                    if (rd_cnt_reg == LAST_MUTE_ADDR)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        priority if (emit_data)
        begin
            out_valid_next = 1'b1;
            out_addr_next  = pend_idx_reg;
            out_data_next  = ram_rdata;
            out_last_next  = (pend_idx_reg == B12_ADDR) && !has13;
        end
        else if (emit13)
        begin
            out_valid_next = 1'b1;
            out_addr_next  = B13_ADDR;
            out_data_next  = b13_reg;
            out_last_next  = 1'b1;
        end
        else if (mute_emit)
        begin
            out_valid_next = 1'b1;
            out_addr_next  = rd_cnt_reg;
            out_data_next  = '0;
            out_last_next  = (rd_cnt_reg == LAST_MUTE_ADDR);
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            frames_left_reg <= '0;
            ptr_reg         <= '0;
            is_load_reg     <= 1'b0;
            rd_cnt_reg      <= '0;
            rd_more_reg     <= 1'b0;
            pend_reg        <= 1'b0;
            emit13_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            frames_left_reg <= frames_left_next;
            ptr_reg         <= ptr_next;
            is_load_reg     <= is_load_next;
            rd_cnt_reg      <= rd_cnt_next;
            rd_more_reg     <= rd_more_next;
            pend_reg        <= pend_next;
            emit13_reg      <= emit13_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        load_byte_reg <= load_byte_next;
        pend_idx_reg  <= pend_idx_next;
        b13_reg       <= b13_next;
        out_addr_reg  <= out_addr_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    assign item_stall    = (state_reg != S_IDLE);
    assign red_req.start = accept && ((mode == MODE_LOAD) || (mode == MODE_START));
    assign red_req.value = (mode == MODE_LOAD) ? load_index : cfg_start_offset;
    assign ram_we        = (state_reg == S_REDUCE) && red_rsp.done && is_load_reg;
    assign ram_waddr     = red_ptr;
    assign ram_wdata     = load_byte_reg;
    assign ram_re        = issue;
    assign ram_raddr     = rd_addr;
    assign result_valid  = out_valid_reg;
    assign reg_addr      = out_addr_reg;
    assign reg_data      = out_data_reg;
    assign last          = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/psg_register_frame_player.sv
// Tick with frames left: register writes read from the ring RAM, one ring RAM read a cycle
//   while the output is not stalled; register 13 is skipped when its byte is the skip mark.
// Tick with no frames left: sixteen mute writes, one a cycle while the output is not stalled.
// Load and start: the position or offset is reduced modulo the ring size before the block
//   returns to idle. Reset clears control and configuration, and the ring is undefined
//   until loaded.
// ----------------------------------------------------------------------------
// psg_register_frame_player
// Plays a sound chip register dump stored in a byte ring held in RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_register_frame_player #(
    parameter int SECTORS      = psgfp_pkg::SECTORS_DEF,
    parameter int SECTOR_BYTES = psgfp_pkg::SECTOR_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // item channel
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [psgfp_pkg::MODE_W-1:0]      mode,
    input  logic [psgfp_pkg::IDX_W-1:0]       load_index,
    input  logic [psgfp_pkg::BYTE_W-1:0]      load_byte,
    // register write channel
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [psgfp_pkg::RADDR_W-1:0]     reg_addr,
    output logic [psgfp_pkg::BYTE_W-1:0]      reg_data,
    output logic                              last,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [psgfp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psgfp_pkg::CFG_W-1:0]       cfg_data
);

    import psgfp_pkg::*;

    localparam int RING = SECTORS * SECTOR_BYTES;
    localparam int AW   = $clog2(RING);

    logic [COUNT_W-1:0] cfg_frame_count_reg;
    logic [COUNT_W-1:0] cfg_frame_count_next;
    logic [IDX_W-1:0]   cfg_start_offset_reg;
    logic [IDX_W-1:0]   cfg_start_offset_next;

    red_req_t           red_req;
    red_rsp_t           red_rsp;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [BYTE_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [BYTE_W-1:0]  ram_rdata;

    // Configuration registers: the user must write them only while the block is idle (the block
    // does not enforce this), so the player samples them directly when a start item transfers.
    always_comb
    begin
        cfg_frame_count_next  = cfg_frame_count_reg;
        cfg_start_offset_next = cfg_start_offset_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_COUNT:
                begin
                    cfg_frame_count_next = cfg_data;
                end
                CFG_START_OFFSET:
                begin
                    cfg_start_offset_next = cfg_data[IDX_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_frame_count_reg  <= '0;
            cfg_start_offset_reg <= '0;
        end
        else
        begin
            cfg_frame_count_reg  <= cfg_frame_count_next;
            cfg_start_offset_reg <= cfg_start_offset_next;
        end
    end

    // Ring store: loads write through the write port, playback reads ahead
    // one byte through the read port.
    psgfp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared modulo unit for load positions and start offsets
    psgfp_reduce #(
        .RING (RING)
    ) u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (red_req),
        .rsp   (red_rsp)
    );

    // Sequencer: one item at a time; a tick streams its writes through the
    // output register, which also lets the next item transfer while the
    // final write of a tick still waits downstream.
    psgfp_player #(
        .SECTORS      (SECTORS),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_player (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .mode             (mode),
        .load_index       (load_index),
        .load_byte        (load_byte),
        .cfg_frame_count  (cfg_frame_count_reg),
        .cfg_start_offset (cfg_start_offset_reg),
        .red_req          (red_req),
        .red_rsp          (red_rsp),
        .ram_we           (ram_we),
        .ram_waddr        (ram_waddr),
        .ram_wdata        (ram_wdata),
        .ram_re           (ram_re),
        .ram_raddr        (ram_raddr),
        .ram_rdata        (ram_rdata),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .reg_addr         (reg_addr),
        .reg_data         (reg_data),
        .last             (last)
    );

endmodule

`default_nettype wire

// File: rtl/core/psgfp_checker.sv
// ----------------------------------------------------------------------------
// psgfp_checker
// Port-level checks of the register frame player, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "psg_register_frame_player_assert.svh"

module psgfp_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  logic                            item_stall,
    input  logic [psgfp_pkg::MODE_W-1:0]    mode,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  logic [psgfp_pkg::RADDR_W-1:0]   reg_addr,
    input  logic [psgfp_pkg::BYTE_W-1:0]    reg_data,
    input  logic                            last
);

    import psgfp_pkg::*;

    // A load transfer occupies the block while its position is reduced
    `PSGFP_ASSERT_NEXT(a_load_busy, item_valid && !item_stall && mode == MODE_LOAD, item_stall, "load transfer did not hold the item channel")

    // A tick transfer always starts a write burst that holds the block
    `PSGFP_ASSERT_NEXT(a_tick_busy, item_valid && !item_stall && mode == MODE_TICK, item_stall, "tick transfer did not hold the item channel")

    // Register 15 only appears as the closing mute write
    `PSGFP_ASSERT_SAME(a_mute_last, result_valid && reg_addr == LAST_MUTE_ADDR, last, "register 15 write without last")

    // A burst can only close on register 12, 13 or 15
    `PSGFP_ASSERT_SAME(a_last_addr, result_valid && last, reg_addr == B12_ADDR || reg_addr == B13_ADDR || reg_addr == LAST_MUTE_ADDR, "last on an unexpected register")

    // Hold a stalled write
    `PSGFP_ASSERT_NEXT(a_out_hold, result_valid && result_stall, result_valid && $stable(reg_addr) && $stable(reg_data) && $stable(last), "stalled register write changed")

endmodule

bind psg_register_frame_player psgfp_checker u_checker (.*);

`default_nettype wire
